FILE: rtl/core/assert_macros.svh
// Assertion macros for the morse text gate sequencer RTL.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define MTG_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Invariant that must hold at every clock edge outside reset.
`define MTG_ASSERT_ALWAYS(label, expr, msg) \
    `MTG_ASSERT_CLK(label, (expr), msg)

`endif

FILE: rtl/core/mtg_pkg.sv
// Package for the morse text gate sequencer: sizes, codes, command types
// and the Morse character table. Depends on nothing.
package mtg_pkg;

    localparam int SYM_DEPTH = 1024;
    localparam int SYM_AW    = $clog2(SYM_DEPTH);
    localparam int LEN_W     = SYM_AW + 1;
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_APPEND = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        SYM_DOT    = 3'd0,
        SYM_DASH   = 3'd1,
        SYM_INTRA  = 3'd2,
        SYM_LETTER = 3'd3,
        SYM_WORD   = 3'd4
    } t_sym;

    typedef enum logic [1:0] {
        CFG_SAMPLE_RATE = 2'd0,
        CFG_TIMEOUT     = 2'd1,
        CFG_MIN_PERIOD  = 2'd2
    } t_cfg_idx;

    // Element pattern: pat[4] is the first element, 1 means dash.
    typedef struct packed {
        logic       known;
        logic [2:0] len;
        logic [4:0] pat;
    } t_morse;

    typedef struct packed {
        t_op        op;
        logic       is_space;
        t_morse     morse;
        logic       run_toggle;
        logic       reset_pulse;
        logic       clk_conn;
        logic       clk_edge;
        logic [12:0] rate;
    } t_cmd;

    typedef struct packed {
        logic [24:0] sr100;
        logic [19:0] timeout;
        logic [9:0]  min_period;
    } t_cfg;

    // Duration of each symbol in units.
    function automatic logic [2:0] sym_units(input t_sym s);
        logic [2:0] u;
        case (s)
            SYM_DOT:    u = 3'd1;
            SYM_DASH:   u = 3'd2;
            SYM_INTRA:  u = 3'd1;
            SYM_LETTER: u = 3'd3;
            SYM_WORD:   u = 3'd7;
            default:    u = 3'd0;
        endcase
        return u;
    endfunction

    // Morse table for upper case letters and digits.
    function automatic t_morse morse_lookup(input logic [7:0] c);
        t_morse m;
        m = '{1'b1, 3'd0, 5'b00000};
        case (c)
            8'h41: m = '{1'b1, 3'd2, 5'b01000};
            8'h42: m = '{1'b1, 3'd4, 5'b10000};
            8'h43: m = '{1'b1, 3'd4, 5'b10100};
            8'h44: m = '{1'b1, 3'd3, 5'b10000};
            8'h45: m = '{1'b1, 3'd1, 5'b00000};
            8'h46: m = '{1'b1, 3'd4, 5'b00100};
            8'h47: m = '{1'b1, 3'd3, 5'b11000};
            8'h48: m = '{1'b1, 3'd4, 5'b00000};
            8'h49: m = '{1'b1, 3'd2, 5'b00000};
            8'h4A: m = '{1'b1, 3'd4, 5'b01110};
            8'h4B: m = '{1'b1, 3'd3, 5'b10100};
            8'h4C: m = '{1'b1, 3'd4, 5'b01000};
            8'h4D: m = '{1'b1, 3'd2, 5'b11000};
            8'h4E: m = '{1'b1, 3'd2, 5'b10000};
            8'h4F: m = '{1'b1, 3'd3, 5'b11100};
            8'h50: m = '{1'b1, 3'd4, 5'b01100};
            8'h51: m = '{1'b1, 3'd4, 5'b11010};
            8'h52: m = '{1'b1, 3'd3, 5'b01000};
            8'h53: m = '{1'b1, 3'd3, 5'b00000};
            8'h54: m = '{1'b1, 3'd1, 5'b10000};
            8'h55: m = '{1'b1, 3'd3, 5'b00100};
            8'h56: m = '{1'b1, 3'd4, 5'b00010};
            8'h57: m = '{1'b1, 3'd3, 5'b01100};
            8'h58: m = '{1'b1, 3'd4, 5'b10010};
            8'h59: m = '{1'b1, 3'd4, 5'b10110};
            8'h5A: m = '{1'b1, 3'd4, 5'b11000};
            8'h30: m = '{1'b1, 3'd5, 5'b11111};
            8'h31: m = '{1'b1, 3'd5, 5'b01111};
            8'h32: m = '{1'b1, 3'd5, 5'b00111};
            8'h33: m = '{1'b1, 3'd5, 5'b00011};
            8'h34: m = '{1'b1, 3'd5, 5'b00001};
            8'h35: m = '{1'b1, 3'd5, 5'b00000};
            8'h36: m = '{1'b1, 3'd5, 5'b10000};
            8'h37: m = '{1'b1, 3'd5, 5'b11000};
            8'h38: m = '{1'b1, 3'd5, 5'b11100};
            8'h39: m = '{1'b1, 3'd5, 5'b11110};
            default: m = '{1'b0, 3'd0, 5'b00000};
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/mtg_front.sv
// Front end: accepts input transactions, folds case, looks up the Morse
// pattern and clamps the rate. Depends on mtg_pkg.
module mtg_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_operation,
    input  logic [7:0]      i_char_code,
    input  logic            i_run_toggle,
    input  logic            i_reset_pulse,
    input  logic            i_clock_connected,
    input  logic            i_clock_edge,
    input  logic [13:0]     i_rate_centihz,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output mtg_pkg::t_cmd   o_cmd
);
    import mtg_pkg::*;

    logic       r_valid;
    t_cmd       r_cmd;
    t_cmd       n_cmd;
    logic [7:0] w_upper;

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Classify the incoming transaction.
    always_comb begin
        if (i_char_code >= 8'h61 && i_char_code <= 8'h7A) begin
            w_upper = i_char_code - 8'h20;
        end else begin
            w_upper = i_char_code;
        end
        n_cmd.op          = t_op'(i_operation);
        n_cmd.is_space    = (i_char_code == 8'h20) || (i_char_code == 8'h0A) ||
                            (i_char_code == 8'h09);
        n_cmd.morse       = morse_lookup(w_upper);
        n_cmd.run_toggle  = i_run_toggle;
        n_cmd.reset_pulse = i_reset_pulse;
        n_cmd.clk_conn    = i_clock_connected;
        n_cmd.clk_edge    = i_clock_edge;
        if ($signed(i_rate_centihz) < 14'sd10) begin
            n_cmd.rate = 13'd10;
        end else if ($signed(i_rate_centihz) > 14'sd5000) begin
            n_cmd.rate = 13'd5000;
        end else begin
            n_cmd.rate = i_rate_centihz[12:0];
        end
    end

    // Holding register toward the command queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: rtl/core/mtg_queue.sv
// Short command queue between the front end and the back end.
// Depends on mtg_pkg.
module mtg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  mtg_pkg::t_cmd   i_push_cmd,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output mtg_pkg::t_cmd   o_pop_cmd
);
    import mtg_pkg::*;

    t_cmd            r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != (Q_AW + 1)'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_q[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Pointer and occupancy tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

FILE: rtl/core/mtg_back.sv
// Back end: symbol store, text expansion, symbol timing and clock capture.
// Depends on mtg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mtg_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtg_pkg::t_cfg     i_cfg,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  mtg_pkg::t_cmd     i_cmd,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_gate,
    output logic              o_running,
    output logic [mtg_pkg::LEN_W-1:0] o_symbol_index,
    output logic              o_store_full
);
    import mtg_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PUSH  = 10'b0000000010,
        S_NORM  = 10'b0000000100,
        S_RD    = 10'b0000001000,
        S_OUT   = 10'b0000010000,
        S_TGATE = 10'b0000100000,
        S_TRD   = 10'b0001000000,
        S_TSYM  = 10'b0010000000,
        S_TMUL  = 10'b0100000000,
        S_TCMP  = 10'b1000000000
    } t_state;

    t_state           r_state;
    t_cmd             r_cmd;
    t_sym             r_mem [SYM_DEPTH];
    t_sym             r_rd_data;
    logic [LEN_W-1:0] r_body;
    logic [LEN_W-1:0] r_pos;
    logic             r_in_word;
    logic             r_word_seen;
    logic             r_word_has_char;
    logic             r_run;
    logic             r_dropped;
    logic [31:0]      r_sym_timer;
    logic [31:0]      r_clk_timer;
    logic [31:0]      r_clk_period;
    logic             r_locked;
    logic             r_pend_word;
    logic             r_pend_letter;
    logic             r_intra;
    logic [2:0]       r_elem;
    logic             r_gate_old;
    logic             r_active;
    logic [2:0]       r_units;
    logic [34:0]      r_prod_clk;
    logic [44:0]      r_prod_t;
    logic [27:0]      r_prod_f;
    logic             r_use_clk;
    logic             r_out_valid;
    logic             r_gate;
    logic             r_running;
    logic [LEN_W-1:0] r_index;
    logic             r_full;

    logic             w_pop;
    logic             w_beyond;
    t_sym             w_sym;
    t_sym             w_push_sym;
    logic             w_push_last;
    logic             w_we;
    logic             w_push_full;
    logic             w_done;
    logic [LEN_W-1:0] n_pos;
    logic [31:0]      n_clk_timer;
    logic [31:0]      n_clk_period;
    logic             n_locked;

    assign o_cmd_ready    = (r_state == S_IDLE) && !r_out_valid;
    assign w_pop          = o_cmd_ready && i_cmd_valid;
    assign o_out_valid    = r_out_valid;
    assign o_gate         = r_gate;
    assign o_running      = r_running;
    assign o_symbol_index = r_index;
    assign o_store_full   = r_full;

    // Position past the sequence end; the virtual trailing gap sits at r_body.
    assign w_beyond    = (r_body == '0) || (r_pos > r_body);
    assign w_sym       = (r_pos >= r_body) ? SYM_WORD : r_rd_data;
    assign w_we        = (r_state == S_PUSH) && (r_body != LEN_W'(SYM_DEPTH));
    assign w_push_full = (r_state == S_PUSH) && (r_body == LEN_W'(SYM_DEPTH));

    // Select the next symbol written while expanding a character.
    always_comb begin
        w_push_sym  = SYM_DOT;
        w_push_last = 1'b0;
        if (r_pend_word) begin
            w_push_sym  = SYM_WORD;
            w_push_last = !r_cmd.morse.known;
        end else if (r_pend_letter) begin
            w_push_sym = SYM_LETTER;
        end else if (r_intra) begin
            w_push_sym = SYM_INTRA;
        end else begin
            w_push_sym  = r_cmd.morse.pat[3'd4 - r_elem] ? SYM_DASH : SYM_DOT;
            w_push_last = ((r_elem + 3'd1) == r_cmd.morse.len);
        end
    end

    // External clock capture for one sample.
    always_comb begin
        n_clk_timer  = (r_clk_timer != '1) ? r_clk_timer + 32'd1 : r_clk_timer;
        n_clk_period = r_clk_period;
        n_locked     = r_locked;
        if (r_cmd.clk_conn) begin
            if (r_cmd.clk_edge) begin
                n_clk_period = n_clk_timer;
                n_clk_timer  = '0;
                n_locked     = 1'b1;
            end
            if (n_clk_timer > {12'd0, i_cfg.timeout}) begin
                n_locked = 1'b0;
            end
        end else begin
            n_locked    = 1'b0;
            n_clk_timer = '0;
        end
    end

    // End of symbol test and the advanced position.
    always_comb begin
        if (r_use_clk) begin
            w_done = ({3'd0, r_sym_timer} >= r_prod_clk);
        end else begin
            w_done = (r_prod_t >= {17'd0, r_prod_f});
        end
        n_pos = r_pos;
        if (r_active && w_done) begin
            n_pos = (r_pos >= r_body) ? '0 : r_pos + 1'b1;
        end
    end

    // Symbol store: one write port, one registered read at the position.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_body[SYM_AW-1:0]] <= w_push_sym;
        end
        r_rd_data <= r_mem[r_pos[SYM_AW-1:0]];
    end

    // Sequencer for one transaction at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_body          <= '0;
            r_pos           <= '0;
            r_in_word       <= 1'b0;
            r_word_seen     <= 1'b0;
            r_word_has_char <= 1'b0;
            r_run           <= 1'b0;
            r_dropped       <= 1'b0;
            r_sym_timer     <= '0;
            r_clk_timer     <= '0;
            r_clk_period    <= '0;
            r_locked        <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.op)
                            OP_TICK: begin
                                r_state <= S_TGATE;
                            end
                            OP_APPEND: begin
                                if (i_cmd.is_space) begin
                                    r_in_word       <= 1'b0;
                                    r_word_has_char <= 1'b0;
                                    r_state         <= S_NORM;
                                end else begin
                                    r_pend_word     <= !r_in_word && r_word_seen;
                                    r_pend_letter   <= i_cmd.morse.known && r_word_has_char;
                                    r_in_word       <= 1'b1;
                                    r_word_seen     <= 1'b1;
                                    r_word_has_char <= 1'b1;
                                    r_intra         <= 1'b0;
                                    r_elem          <= '0;
                                    if (!i_cmd.morse.known && !(!r_in_word && r_word_seen)) begin
                                        r_state <= S_NORM;
                                    end else begin
                                        r_state <= S_PUSH;
                                    end
                                end
                            end
                            OP_CLEAR: begin
                                r_body          <= '0;
                                r_in_word       <= 1'b0;
                                r_word_seen     <= 1'b0;
                                r_word_has_char <= 1'b0;
                                r_dropped       <= 1'b0;
                                r_pos           <= '0;
                                r_state         <= S_NORM;
                            end
                            default: begin
                                r_state <= S_NORM;
                            end
                        endcase
                    end
                end
                S_PUSH: begin
                    if (w_we) begin
                        r_body <= r_body + 1'b1;
                    end else begin
                        r_dropped <= 1'b1;
                    end
                    if (r_pend_word) begin
                        r_pend_word <= 1'b0;
                    end else if (r_pend_letter) begin
                        r_pend_letter <= 1'b0;
                    end else if (r_intra) begin
                        r_intra <= 1'b0;
                    end else begin
                        r_elem  <= r_elem + 3'd1;
                        r_intra <= 1'b1;
                    end
                    if (w_push_last) begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (w_beyond) begin
                        r_pos <= '0;
                    end
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_gate      <= r_run && !w_beyond && (w_sym <= SYM_DASH);
                    r_running   <= r_run;
                    r_index     <= r_pos;
                    r_full      <= r_dropped;
                    r_state     <= S_IDLE;
                end
                S_TGATE: begin
                    r_gate_old   <= r_run && !w_beyond && (w_sym <= SYM_DASH);
                    r_run        <= r_run ^ r_cmd.run_toggle;
                    if (r_cmd.reset_pulse) begin
                        r_pos       <= '0;
                        r_sym_timer <= '0;
                    end
                    r_clk_timer  <= n_clk_timer;
                    r_clk_period <= n_clk_period;
                    r_locked     <= n_locked;
                    r_state      <= S_TRD;
                end
                S_TRD: begin
                    r_state <= S_TSYM;
                end
                S_TSYM: begin
                    r_active <= r_run && !w_beyond;
                    r_units  <= sym_units(w_sym);
                    if (r_run && !w_beyond && (r_sym_timer != '1)) begin
                        r_sym_timer <= r_sym_timer + 32'd1;
                    end
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    r_prod_clk <= 35'(r_units) * 35'(r_clk_period);
                    r_prod_t   <= 45'(r_sym_timer) * 45'(r_cmd.rate);
                    r_prod_f   <= 28'(r_units) * 28'(i_cfg.sr100);
                    r_use_clk  <= r_locked && (r_clk_period > {22'd0, i_cfg.min_period});
                    r_state    <= S_TCMP;
                end
                S_TCMP: begin
                    if (r_active && w_done) begin
                        r_sym_timer <= '0;
                    end
                    r_pos       <= n_pos;
                    r_out_valid <= 1'b1;
                    r_gate      <= r_gate_old;
                    r_running   <= r_run;
                    r_index     <= n_pos;
                    r_full      <= r_dropped;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The body never grows past the store, and the position stays in the sequence.
    `MTG_ASSERT_ALWAYS(a_body_bound, r_body <= LEN_W'(SYM_DEPTH), "symbol body exceeds store")
    `MTG_ASSERT_ALWAYS(a_pos_bound, r_pos <= r_body, "position beyond sequence end")
    // A push into a full store must raise the dropped flag.
    `MTG_ASSERT_CLK(a_drop_flag, w_push_full |=> r_dropped, "full store push not flagged")

endmodule

FILE: rtl/core/morse_text_gate_sequencer_unit.sv
// A tick passes the front register, the queue and the back-end states TGATE,
// TRD, TSYM, TMUL and TCMP; an append makes one symbol store write per cycle
// in PUSH, then NORM, RD, OUT. The back end takes one transaction per pass,
// none while a result waits; the front end and a two-entry queue buffer more.
// Reset: synchronous active-low; clears text, run state and timers, and
// restores the default configuration.
module morse_text_gate_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_char_code,
    input  logic        i_run_toggle,
    input  logic        i_reset_pulse,
    input  logic        i_clock_connected,
    input  logic        i_clock_edge,
    input  logic [13:0] i_rate_centihz,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_gate,
    output logic        o_running,
    output logic [10:0] o_symbol_index,
    output logic        o_store_full
);
    import mtg_pkg::*;

    t_cfg r_cfg;
    logic w_f_valid;
    logic w_f_ready;
    t_cmd w_f_cmd;
    logic w_q_valid;
    logic w_q_ready;
    t_cmd w_q_cmd;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; the sample rate is kept scaled by 100.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sr100      <= 25'd4800000;
            r_cfg.timeout    <= 20'd240000;
            r_cfg.min_period <= 10'd48;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SAMPLE_RATE: r_cfg.sr100      <= 25'(i_cfg_data[17:0]) * 25'd100;
                CFG_TIMEOUT:     r_cfg.timeout    <= i_cfg_data;
                CFG_MIN_PERIOD:  r_cfg.min_period <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    mtg_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_char_code       (i_char_code),
        .i_run_toggle      (i_run_toggle),
        .i_reset_pulse     (i_reset_pulse),
        .i_clock_connected (i_clock_connected),
        .i_clock_edge      (i_clock_edge),
        .i_rate_centihz    (i_rate_centihz),
        .o_cmd_valid       (w_f_valid),
        .i_cmd_ready       (w_f_ready),
        .o_cmd             (w_f_cmd)
    );

    mtg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_cmd   (w_f_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_cmd    (w_q_cmd)
    );

    mtg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd_valid    (w_q_valid),
        .o_cmd_ready    (w_q_ready),
        .i_cmd          (w_q_cmd),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_gate         (o_gate),
        .o_running      (o_running),
        .o_symbol_index (o_symbol_index),
        .o_store_full   (o_store_full)
    );

endmodule

FILE: test/testbench.sv
// Testbench for morse_text_gate_sequencer_unit: random and directed traffic
// checked against a behavioral predictor. Depends on mtg_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import mtg_pkg::*;

    typedef struct packed {
        t_op         op;
        logic [7:0]  chr;
        logic        tog;
        logic        rst;
        logic        conn;
        logic        edg;
        logic [13:0] rate;
    } t_item;

    typedef struct packed {
        logic        gate;
        logic        running;
        logic [10:0] index;
        logic        full;
    } t_status;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [19:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_operation;
    logic [7:0]  i_char_code;
    logic        i_run_toggle;
    logic        i_reset_pulse;
    logic        i_clock_connected;
    logic        i_clock_edge;
    logic [13:0] i_rate_centihz;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_gate;
    logic        o_running;
    logic [10:0] o_symbol_index;
    logic        o_store_full;

    morse_text_gate_sequencer_unit i_dut (.*);

    // Predictor state.
    logic [31:0] p_sample_rate;
    logic [31:0] p_timeout;
    logic [31:0] p_min_period;
    logic [2:0]  p_store [SYM_DEPTH];
    int unsigned p_len;
    bit          p_in_word, p_word_seen, p_has_char, p_run, p_dropped, p_locked;
    int unsigned p_pos;
    logic [31:0] p_sym_timer, p_clk_timer, p_clk_period;

    t_item   pending_items[$];
    t_status expected_status[$];
    bit      failed;
    bit      idle_off;
    int      hold_cnt;
    int      tx_gap, rx_gap, stall_cnt;
    logic    o_in_ready_q;

    function automatic int unsigned seq_len();
        return p_len == 0 ? 0 : p_len + 1;
    endfunction

    function automatic t_sym sym_at(int unsigned idx);
        if (idx >= p_len) return SYM_WORD;
        return t_sym'(p_store[idx]);
    endfunction

    function automatic bit gate_now();
        if (!p_run || p_pos >= seq_len()) return 0;
        return sym_at(p_pos) <= SYM_DASH;
    endfunction

    function automatic void push_sym(t_sym s);
        if (p_len < SYM_DEPTH) begin
            p_store[p_len] = s;
            p_len++;
        end else begin
            p_dropped = 1;
        end
    endfunction

    // Append one item at the tail of the pending queue.
    function automatic void add_item(t_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // Element strings per character; '.' dot, '-' dash.
    function automatic string morse_of(logic [7:0] c);
        string letters[26] = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....",
            "..", ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
            "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
        string digits[10] = '{"-----", ".----", "..---", "...--", "....-",
            ".....", "-....", "--...", "---..", "----."};
        if (c >= "a" && c <= "z") c = c - 8'd32;
        if (c >= "A" && c <= "Z") return letters[c - "A"];
        if (c >= "0" && c <= "9") return digits[c - "0"];
        return "";
    endfunction

    function automatic void append_char(logic [7:0] c);
        string m;
        if (c == 8'h20 || c == 8'h0A || c == 8'h09) begin
            p_in_word = 0;
            p_has_char = 0;
            return;
        end
        if (!p_in_word) begin
            if (p_word_seen) push_sym(SYM_WORD);
            p_word_seen = 1;
            p_in_word = 1;
        end
        m = morse_of(c);
        if (m.len() > 0) begin
            if (p_has_char) push_sym(SYM_LETTER);
            for (int j = 0; j < m.len(); j++) begin
                if (j > 0) push_sym(SYM_INTRA);
                push_sym(m[j] == "." ? SYM_DOT : SYM_DASH);
            end
        end
        p_has_char = 1;
    endfunction

    function automatic void tick(t_item it);
        logic [63:0] units;
        bit          done;
        int          r;
        if (it.tog) p_run = !p_run;
        if (it.rst) begin
            p_pos = 0;
            p_sym_timer = 0;
        end
        if (p_clk_timer != 32'hFFFF_FFFF) p_clk_timer++;
        if (it.conn) begin
            if (it.edg) begin
                p_clk_period = p_clk_timer;
                p_clk_timer = 0;
                p_locked = 1;
            end
            if (p_clk_timer > p_timeout) p_locked = 0;
        end else begin
            p_locked = 0;
            p_clk_timer = 0;
        end
        if (!p_run || p_pos >= seq_len()) return;
        case (sym_at(p_pos))
            SYM_DOT, SYM_INTRA: units = 1;
            SYM_DASH:           units = 2;
            SYM_LETTER:         units = 3;
            default:            units = 7;
        endcase
        if (p_sym_timer != 32'hFFFF_FFFF) p_sym_timer++;
        if (p_locked && p_clk_period > p_min_period) begin
            done = 64'(p_sym_timer) >= units * 64'(p_clk_period);
        end else begin
            r = $signed(it.rate);
            if (r < 10) r = 10;
            if (r > 5000) r = 5000;
            done = 64'(p_sym_timer) * 64'(r) >= units * 64'(p_sample_rate) * 64'd100;
        end
        if (done) begin
            p_sym_timer = 0;
            p_pos++;
            if (p_pos >= seq_len()) p_pos = 0;
        end
    endfunction

    function automatic t_status predict_status(t_item it);
        t_status s;
        if (it.op == OP_TICK) begin
            s.gate = gate_now();
            tick(it);
        end else begin
            if (it.op == OP_APPEND) begin
                append_char(it.chr);
            end else if (it.op == OP_CLEAR) begin
                p_len = 0;
                p_in_word = 0;
                p_word_seen = 0;
                p_has_char = 0;
                p_dropped = 0;
                p_pos = 0;
            end
            if (p_pos >= seq_len()) p_pos = 0;
            s.gate = gate_now();
        end
        s.running = p_run;
        s.index = p_pos[10:0];
        s.full = p_dropped;
        return s;
    endfunction

    function automatic t_item rand_tick(int rlo, int rhi);
        t_item it;
        it.op = OP_TICK;
        it.chr = 8'($urandom);
        it.tog = ($urandom_range(0, 15) == 0);
        it.rst = ($urandom_range(0, 63) == 0);
        it.conn = ($urandom_range(0, 3) != 0);
        it.edg = ($urandom_range(0, 7) == 0);
        it.rate = 14'($urandom_range(rlo, rhi));
        return it;
    endfunction

    function automatic t_item make_item(t_op op, logic [7:0] c);
        t_item it;
        it = rand_tick(0, 16383);
        it.op = op;
        it.chr = c;
        return it;
    endfunction

    // Clock.
    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Input driver: fed from the pending item queue.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
        end else if (!i_in_valid || o_in_ready_q) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_in_valid <= 0;
            end else if (!idle_off && $urandom_range(0, 9) == 0) begin
                tx_gap <= $urandom_range(1, 16);
                i_in_valid <= 0;
            end else if (pending_items.size() > 0) begin
                t_item it;
                it = pending_items.pop_front();
                i_in_valid <= 1;
                i_operation <= it.op;
                i_char_code <= it.chr;
                i_run_toggle <= it.tog;
                i_reset_pulse <= it.rst;
                i_clock_connected <= it.conn;
                i_clock_edge <= it.edg;
                i_rate_centihz <= it.rate;
            end else begin
                i_in_valid <= 0;
            end
        end
    end

    // Acceptance seen at the last rising edge, used by the driver.
    always @(posedge i_clk) begin
        o_in_ready_q <= i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            expected_status.insert(expected_status.size(),
                predict_status(t_item'{t_op'(i_operation),
                i_char_code, i_run_toggle, i_reset_pulse, i_clock_connected,
                i_clock_edge, i_rate_centihz}));
    end

    // Result monitor and checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_status got, want;
            got = '{o_gate, o_running, o_symbol_index, o_store_full};
            if (expected_status.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                failed = 1;
            end else begin
                want = expected_status.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    failed = 1;
                end
            end
        end
    end

    // Receiver ready with random stall bursts and a counted long hold-off.
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_ready <= 0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_out_ready <= 0;
        end else if (!idle_off && $urandom_range(0, 9) == 0) begin
            rx_gap <= $urandom_range(1, 16);
            i_out_ready <= 0;
        end else begin
            i_out_ready <= 1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || (hold_cnt > 0)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= 20000) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [19:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SAMPLE_RATE: p_sample_rate = val[17:0];
            CFG_TIMEOUT:     p_timeout = val;
            default:         p_min_period = val[9:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_status.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Mostly ticks, with text appended and some noise.
    task automatic random_phase(int count, int rlo, int rhi);
        string words = "HELLO world SOS 0123456789 qz?x\t!\n";
        for (int k = 0; k < count; k++) begin
            int pick = $urandom_range(0, 99);
            if (pick < 20)
                add_item(make_item(OP_APPEND,
                    8'(words[$urandom_range(0, words.len() - 1)])));
            else if (pick < 23)
                add_item(make_item(OP_APPEND, 8'($urandom)));
            else if (pick == 23)
                add_item(make_item(OP_CLEAR, 8'($urandom)));
            else if (pick == 24)
                add_item(make_item(OP_NONE, 8'($urandom)));
            else
                add_item(rand_tick(rlo, rhi));
        end
    endtask

    initial begin
        t_item it;
        failed = 0;
        idle_off = 0;
        hold_cnt = 0;
        tx_gap = 0;
        rx_gap = 0;
        stall_cnt = 0;
        o_in_ready_q = 0;
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_SAMPLE_RATE;
        i_cfg_data = 0;
        i_in_valid = 0;
        i_out_ready = 0;
        i_operation = OP_TICK;
        i_char_code = 0;
        i_run_toggle = 0;
        i_reset_pulse = 0;
        i_clock_connected = 0;
        i_clock_edge = 0;
        i_rate_centihz = 0;
        p_sample_rate = 48000;
        p_timeout = 240000;
        p_min_period = 48;
        p_len = 0;
        p_in_word = 0;
        p_word_seen = 0;
        p_has_char = 0;
        p_run = 0;
        p_dropped = 0;
        p_locked = 0;
        p_pos = 0;
        p_sym_timer = 0;
        p_clk_timer = 0;
        p_clk_period = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Fast free-running units so symbols advance during runs of ticks.
        cfg_write(CFG_SAMPLE_RATE, 20'd1000);
        cfg_write(CFG_TIMEOUT, 20'd1);
        cfg_write(CFG_MIN_PERIOD, 20'd0);

        // Directed: text with both cases, digits, separators, unknowns, then ticks and a clear.
        add_item(make_item(OP_APPEND, "a"));
        add_item(make_item(OP_APPEND, "Z"));
        add_item(make_item(OP_APPEND, " "));
        add_item(make_item(OP_APPEND, "0"));
        add_item(make_item(OP_APPEND, "9"));
        add_item(make_item(OP_APPEND, 8'hFF));
        add_item(make_item(OP_APPEND, 8'h09));
        add_item(make_item(OP_APPEND, "E"));
        add_item(make_item(OP_APPEND, 8'h0A));
        add_item(make_item(OP_APPEND, "?"));
        add_item(make_item(OP_APPEND, "t"));
        add_item(make_item(OP_NONE, 8'h00));
        it = rand_tick(0, 0);
        it.tog = 1; it.rate = 14'h2000;
        add_item(it);
        it.tog = 0; it.rate = 14'h1FFF; it.conn = 1; it.edg = 1;
        add_item(it);
        it.rate = 14'h3FFF; it.rst = 1; it.edg = 0;
        add_item(it);
        it.rst = 0; it.conn = 0; it.rate = 14'd5000;
        repeat (6) add_item(it);
        add_item(make_item(OP_CLEAR, 8'h00));
        drain();

        // Fill the store past its depth, then tick to see the flag stick.
        for (int k = 0; k < 120; k++)
            add_item(make_item(OP_APPEND, "0"));
        random_phase(100, 4000, 7000);
        drain();

        // Long receiver hold-off while the sender keeps offering items.
        random_phase(50, 4000, 7000);
        hold_cnt = 300;
        wait (hold_cnt == 0);
        add_item(make_item(OP_CLEAR, 8'h00));
        random_phase(500, 3000, 7000);
        drain();

        // Clocked timing with a short period and a larger minimum.
        cfg_write(CFG_SAMPLE_RATE, 20'd0);
        cfg_write(CFG_TIMEOUT, 20'd30);
        cfg_write(CFG_MIN_PERIOD, 20'd2);
        random_phase(500, 0, 16383);
        drain();

        // Extremes of the registers.
        cfg_write(CFG_SAMPLE_RATE, 20'h3FFFF);
        cfg_write(CFG_TIMEOUT, 20'hFFFFF);
        cfg_write(CFG_MIN_PERIOD, 20'h3FF);
        random_phase(200, 0, 16383);
        drain();
        cfg_write(CFG_SAMPLE_RATE, 20'd1000);
        cfg_write(CFG_TIMEOUT, 20'd1000000);
        cfg_write(CFG_MIN_PERIOD, 20'd1);

        // Final part without idling.
        idle_off = 1;
        random_phase(500, 2000, 7000);
        drain();

        if (!failed)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
